// ----- src/psd_pkg.sv -----
// Shared types and constants for the parameter stream deframer.
package psd_pkg;

  localparam logic [1:0] KIND_HEADER  = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_END     = 2'd2;

  localparam logic [3:0] ST_OK          = 4'd0;
  localparam logic [3:0] ST_TOO_LARGE   = 4'd1;
  localparam logic [3:0] ST_SHORT_HDR   = 4'd2;
  localparam logic [3:0] ST_MAGIC       = 4'd3;
  localparam logic [3:0] ST_VERSION     = 4'd4;
  localparam logic [3:0] ST_RESERVED    = 4'd5;
  localparam logic [3:0] ST_COUNT       = 4'd6;
  localparam logic [3:0] ST_REC_TRUNC   = 4'd7;
  localparam logic [3:0] ST_PAY_LARGE   = 4'd8;
  localparam logic [3:0] ST_PAY_TRUNC   = 4'd9;
  localparam logic [3:0] ST_ARR_LARGE   = 4'd10;
  localparam logic [3:0] ST_SCALAR_ARR  = 4'd11;
  localparam logic [3:0] ST_REQ_LARGE   = 4'd12;
  localparam logic [3:0] ST_SIZE_MISM   = 4'd13;
  localparam logic [3:0] ST_TRAILING    = 4'd14;

  localparam logic [2:0] CFG_FORMAT_VERSION  = 3'd0;
  localparam logic [2:0] CFG_CONVOLVER_ID    = 3'd1;
  localparam logic [2:0] CFG_COEFFICIENTS_ID = 3'd2;
  localparam logic [2:0] CFG_BAND_LEVELS_ID  = 3'd3;
  localparam logic [2:0] CFG_MAX_PAYLOAD     = 3'd4;
  localparam logic [2:0] CFG_MAX_RECORDS     = 3'd5;
  localparam logic [2:0] CFG_MAX_STREAM      = 3'd6;

  // Magic "V4AP" read as a little-endian word.
  localparam logic [31:0] MAGIC_WORD = 32'h5041_3456;
  localparam int StreamHdrBytes = 12;
  localparam int RecordHdrBytes = 24;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       stream_end;
  } in_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] param_id;
    logic signed [31:0] value_one;
    logic signed [31:0] value_two;
    logic signed [31:0] value_three;
    logic [31:0]        array_size;
    logic [31:0]        payload_len;
    logic [7:0]         payload_byte;
    logic [31:0]        record_index;
    logic [3:0]         status;
    logic               final_res;
  } out_t;

  // One queue entry: an optional record result followed by an optional end status.
  typedef struct packed {
    logic        has_rec;
    logic        has_end;
    out_t        rec;
    logic [31:0] end_index;
    logic [3:0]  end_status;
  } entry_t;

endpackage

// ----- src/psd_front.sv -----
// Front end: configuration registers, byte parser and stream checks.
module psd_front import psd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  input  in_t         in_data,
  input  logic        q_full,
  output logic        push,
  output entry_t      push_entry
);

  typedef enum logic [1:0] {
    PH_STREAM_HDR, PH_RECORD_HDR, PH_PAYLOAD, PH_TRAILING
  } phase_t;

  logic [15:0]        format_version;
  logic signed [31:0] convolver_id, coefficients_id, band_levels_id;
  logic [31:0]        max_payload, max_records, max_stream;

  phase_t       phase, phase_next;
  logic [4:0]   pos, pos_next;
  logic [32:0]  total, total_next;
  logic [31:0]  recs_left, recs_left_next;
  logic [31:0]  rec_cnt, rec_cnt_next;
  logic [191:0] hdr, hdr_next;
  logic [31:0]  pay_left, pay_left_next;
  logic [3:0]   pend, pend_next;
  logic [3:0]   first_err, first_err_next;

  logic         accept;
  logic [31:0]  id, arr, len;
  logic [34:0]  req;
  logic [3:0]   st;

  assign accept = in_valid && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      format_version  <= 16'd1;
      convolver_id    <= 32'sd0;
      coefficients_id <= 32'sd1;
      band_levels_id  <= 32'sd2;
      max_payload     <= 32'd65536;
      max_records     <= 32'd256;
      max_stream      <= 32'd1048576;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_FORMAT_VERSION:  format_version  <= cfg_data[15:0];
        CFG_CONVOLVER_ID:    convolver_id    <= cfg_data;
        CFG_COEFFICIENTS_ID: coefficients_id <= cfg_data;
        CFG_BAND_LEVELS_ID:  band_levels_id  <= cfg_data;
        CFG_MAX_PAYLOAD:     max_payload     <= cfg_data;
        CFG_MAX_RECORDS:     max_records     <= cfg_data;
        CFG_MAX_STREAM:      max_stream      <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_next     = phase;
    pos_next       = pos;
    total_next     = total;
    recs_left_next = recs_left;
    rec_cnt_next   = rec_cnt;
    hdr_next       = hdr;
    pay_left_next  = pay_left;
    pend_next      = pend;
    first_err_next = first_err;
    push           = 1'b0;
    push_entry     = '0;
    id  = '0;
    arr = '0;
    len = '0;
    req = '0;
    st  = ST_OK;

    if (accept && in_data.has_byte) begin
      if (total != '1) total_next = total + 33'd1;
      if (first_err == ST_OK) begin
        if (phase == PH_TRAILING) begin
          first_err_next = ST_TRAILING;
        end else if (phase == PH_PAYLOAD) begin
          push_entry.has_rec = 1'b1;
          push_entry.rec.kind = KIND_PAYLOAD;
          push_entry.rec.payload_byte = in_data.data_byte;
          pay_left_next = pay_left - 32'd1;
        end else begin
          if (pos == '0) hdr_next = '0;
          hdr_next[int'(pos)*8 +: 8] = in_data.data_byte;
          pos_next = pos + 5'd1;
          if (phase == PH_STREAM_HDR && int'(pos) == StreamHdrBytes - 1) begin
            pos_next = '0;
            if (hdr_next[31:0] != MAGIC_WORD) first_err_next = ST_MAGIC;
            else if (hdr_next[47:32] != format_version) first_err_next = ST_VERSION;
            else if (hdr_next[63:48] != '0) first_err_next = ST_RESERVED;
            else if (hdr_next[95:64] > max_records) first_err_next = ST_COUNT;
            else begin
              recs_left_next = hdr_next[95:64];
              phase_next = (hdr_next[95:64] != '0) ? PH_RECORD_HDR : PH_TRAILING;
            end
          end else if (phase == PH_RECORD_HDR && int'(pos) == RecordHdrBytes - 1) begin
            pos_next = '0;
            id  = hdr_next[31:0];
            arr = hdr_next[159:128];
            len = hdr_next[191:160];
            if (len > max_payload) begin
              first_err_next = ST_PAY_LARGE;
            end else begin
              // The first matching id wins when two id registers are equal.
              if (id == convolver_id)         req = {1'b0, arr, 2'b00};
              else if (id == coefficients_id) req = {arr, 3'b000};
              else if (id == band_levels_id)  req = {1'b0, arr, 2'b00};
              if (arr > max_payload) pend_next = ST_ARR_LARGE;
              else if (req == '0)
                pend_next = (len != '0 || arr != '0) ? ST_SCALAR_ARR : ST_OK;
              else if (req > {3'b000, max_payload}) pend_next = ST_REQ_LARGE;
              else if ({3'b000, len} != req) pend_next = ST_SIZE_MISM;
              else pend_next = ST_OK;
              push_entry.has_rec = 1'b1;
              push_entry.rec.kind = KIND_HEADER;
              pay_left_next = len;
              phase_next = PH_PAYLOAD;
            end
          end
        end
        // Record completion, shared by empty payloads and the last payload byte.
        if (push_entry.has_rec && pay_left_next == '0) begin
          if (pend_next != ST_OK) first_err_next = pend_next;
          pend_next = ST_OK;
          rec_cnt_next = rec_cnt + 32'd1;
          recs_left_next = recs_left - 32'd1;
          phase_next = (recs_left_next != '0) ? PH_RECORD_HDR : PH_TRAILING;
        end
      end
    end

    push_entry.rec.param_id     = hdr_next[31:0];
    push_entry.rec.value_one    = hdr_next[63:32];
    push_entry.rec.value_two    = hdr_next[95:64];
    push_entry.rec.value_three  = hdr_next[127:96];
    push_entry.rec.array_size   = hdr_next[159:128];
    push_entry.rec.payload_len  = hdr_next[191:160];
    push_entry.rec.record_index = rec_cnt;

    if (accept && in_data.stream_end) begin
      if (total_next == '0) st = ST_OK;
      else if (total_next > {1'b0, max_stream}) st = ST_TOO_LARGE;
      else if (first_err_next != ST_OK) st = first_err_next;
      else begin
        case (phase_next)
          PH_STREAM_HDR: st = ST_SHORT_HDR;
          PH_RECORD_HDR: st = ST_REC_TRUNC;
          PH_PAYLOAD:    st = ST_PAY_TRUNC;
          default:       st = ST_OK;
        endcase
      end
      push_entry.has_end    = 1'b1;
      push_entry.end_index  = rec_cnt_next;
      push_entry.end_status = st;
      phase_next     = PH_STREAM_HDR;
      pos_next       = '0;
      total_next     = '0;
      recs_left_next = '0;
      rec_cnt_next   = '0;
      hdr_next       = '0;
      pay_left_next  = '0;
      pend_next      = ST_OK;
      first_err_next = ST_OK;
    end
    push = accept && (push_entry.has_rec || push_entry.has_end);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_STREAM_HDR;
      pos       <= '0;
      total     <= '0;
      recs_left <= '0;
      rec_cnt   <= '0;
      hdr       <= '0;
      pay_left  <= '0;
      pend      <= ST_OK;
      first_err <= ST_OK;
    end else begin
      phase     <= phase_next;
      pos       <= pos_next;
      total     <= total_next;
      recs_left <= recs_left_next;
      rec_cnt   <= rec_cnt_next;
      hdr       <= hdr_next;
      pay_left  <= pay_left_next;
      pend      <= pend_next;
      first_err <= first_err_next;
    end
  end

endmodule

// ----- src/psd_queue.sv -----
// Two-entry queue between the parser and the output stage.
module psd_queue import psd_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_entry,
  input  logic   pop,
  output logic   full,
  output logic   not_empty,
  output entry_t head
);

  entry_t     mem [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign full      = count[1];
  assign not_empty = count != 2'd0;
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ----- src/psd_back.sv -----
// Back end: splits queue entries into result transfers through an output register.
module psd_back import psd_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   not_empty,
  input  entry_t head,
  output logic   pop,
  output logic   out_valid,
  input  logic   out_stall,
  output out_t   out_data
);

  logic load;
  logic rec_done;
  logic send_rec;
  out_t end_res;

  assign load     = not_empty && (!out_valid || !out_stall);
  assign send_rec = head.has_rec && !rec_done;
  assign pop      = load && !(send_rec && head.has_end);

  always_comb begin
    end_res              = '0;
    end_res.kind         = KIND_END;
    end_res.record_index = head.end_index;
    end_res.status       = head.end_status;
    end_res.final_res    = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (load) out_data <= send_rec ? head.rec : end_res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      rec_done  <= 1'b0;
    end else begin
      if (load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      if (load) rec_done <= send_rec && head.has_end;
    end
  end

endmodule

// ----- src/param_stream_deframer_core.sv -----
// Top level of the parameter stream deframer.
// Takes one stream byte per cycle while in_stall is low and, per record, gives a
// header result and one result per payload byte, then an end status when
// stream_end is seen. An item is accepted in every cycle while the two-entry
// queue between parser and output stage has room; an item that both completes a
// record step and ends the stream yields two results, which leave one after the
// other through the single output register. A result is written into the queue
// as its byte is accepted and then loaded into the out_data register when free.
// Configuration writes are always accepted (cfg_ready is high) and should be made
// between streams.
module param_stream_deframer_core import psd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_t        out_data
);

  logic   push, pop, q_full, q_not_empty;
  entry_t push_entry, head;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;

  psd_front u_front (
    .clk, .rst, .cfg_valid, .cfg_index, .cfg_data, .in_valid, .in_data,
    .q_full, .push, .push_entry
  );

  psd_queue u_queue (
    .clk, .rst, .push, .push_entry, .pop,
    .full(q_full), .not_empty(q_not_empty), .head
  );

  psd_back u_back (
    .clk, .rst, .not_empty(q_not_empty), .head, .pop,
    .out_valid, .out_stall, .out_data
  );

endmodule
